@@ rtl/rthc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rthc_pkg
// Shared constants, types and width helpers for the rgb to hsl converter.
// ----------------------------------------------------------------------------
package rthc_pkg;

    localparam int CH_W     = 8;   // color channel width
    localparam int OUT_W    = 15;  // result field width
    localparam int DIV_W    = 9;   // divisor and partial remainder width
    localparam int LANES    = 3;   // divisions carried by every cell

    localparam int LANE_HUE   = 0;
    localparam int LANE_SAT   = 1;
    localparam int LANE_LIGHT = 2;

    localparam int HUE_FRACTION_BITS_DEF     = 6;
    localparam int PERCENT_FRACTION_BITS_DEF = 8;

    // control that travels down the divider chain with each pixel
    typedef struct packed {
        logic valid;
        logic gray;
    } t_ctrl;

    // quotient bits needed to hold the largest rounded hue or percent value
    function automatic int quot_width(input int hfb, input int pfb);
        int hue_max;
        int pct_max;
        int top;
        hue_max = 360 << hfb;
        pct_max = 100 << pfb;
        top     = (hue_max > pct_max) ? hue_max : pct_max;
        return $clog2(top + 1);
    endfunction

endpackage

@@ rtl/rgb_to_hsl_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Converts an 8-bit rgb pixel to hue (degrees), saturation and lightness
// (percent) in fixed point, rounded to nearest, through a chain of divider cells.
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer
//  pixel in  start, busy, i_red/i_green/i_blue       start high while busy low
//  hsl out   o_valid, o_hue/o_saturation/o_lightness o_valid high for one cycle
//
//  one pixel per clock; busy is always low
//  the pipeline has two front-end stages, one divider cell per
//  quotient bit (QW = 15 with the default fraction bits), one output stage
//  synchronous active-low reset empties the pipeline; no results are pending
//  results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter #(
    parameter int HUE_FRACTION_BITS     = rthc_pkg::HUE_FRACTION_BITS_DEF,
    parameter int PERCENT_FRACTION_BITS = rthc_pkg::PERCENT_FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rthc_pkg::CH_W-1:0]   i_red,
    input  logic [rthc_pkg::CH_W-1:0]   i_green,
    input  logic [rthc_pkg::CH_W-1:0]   i_blue,
    output logic                        o_valid,
    output logic [rthc_pkg::OUT_W-1:0]  o_hue,
    output logic [rthc_pkg::OUT_W-1:0]  o_saturation,
    output logic [rthc_pkg::OUT_W-1:0]  o_lightness
);

    localparam int QW = rthc_pkg::quot_width(HUE_FRACTION_BITS, PERCENT_FRACTION_BITS);
    localparam logic [QW-1:0] HUE_FULL = QW'(360 << HUE_FRACTION_BITS);

    rthc_pkg::t_ctrl                                  ctrl_chain [0:QW];
    logic [rthc_pkg::LANES-1:0][rthc_pkg::DIV_W-1:0]  div_chain  [0:QW];
    logic [rthc_pkg::LANES-1:0][rthc_pkg::DIV_W-1:0]  rem_chain  [0:QW];
    logic [rthc_pkg::LANES-1:0][QW-1:0]               bits_chain [0:QW];

    assign busy = 1'b0;

    rthc_prep #(
        .HFB (HUE_FRACTION_BITS),
        .PFB (PERCENT_FRACTION_BITS),
        .QW  (QW)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (start & ~busy),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_ctrl  (ctrl_chain[0]),
        .o_div   (div_chain[0]),
        .o_rem   (rem_chain[0]),
        .o_bits  (bits_chain[0])
    );

    for (genvar k = 0; k < QW; k++) begin : g_cell
        rthc_div_cell #(
            .QW (QW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl_chain[k]),
            .i_div   (div_chain[k]),
            .i_rem   (rem_chain[k]),
            .i_bits  (bits_chain[k]),
            .o_ctrl  (ctrl_chain[k+1]),
            .o_div   (div_chain[k+1]),
            .o_rem   (rem_chain[k+1]),
            .o_bits  (bits_chain[k+1])
        );
    end

    logic [QW-1:0]               q_hue, q_sat, q_light;
    logic                        r_valid;
    logic [rthc_pkg::OUT_W-1:0]  r_hue, r_sat, r_light;
    logic [rthc_pkg::OUT_W-1:0]  n_hue, n_sat;

    always_comb begin
        q_hue   = bits_chain[QW][rthc_pkg::LANE_HUE];
        q_sat   = bits_chain[QW][rthc_pkg::LANE_SAT];
        q_light = bits_chain[QW][rthc_pkg::LANE_LIGHT];
        // gray pixels divided by zero; a full circle wraps to zero
        if (ctrl_chain[QW].gray || (q_hue >= HUE_FULL)) begin
            n_hue = '0;
        end else begin
            n_hue = rthc_pkg::OUT_W'(q_hue);
        end
        n_sat = ctrl_chain[QW].gray ? '0 : rthc_pkg::OUT_W'(q_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= ctrl_chain[QW].valid;
        end
        r_hue   <= n_hue;
        r_sat   <= n_sat;
        r_light <= rthc_pkg::OUT_W'(q_light);
    end

    assign o_valid      = r_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_lightness  = r_light;

endmodule

@@ rtl/rthc_prep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rthc_prep
// Two-stage front end: finds max, min and hue sector, then builds the
// rounding numerators and divisors for the hue, saturation and lightness lanes.
// ----------------------------------------------------------------------------
module rthc_prep #(
    parameter int HFB = rthc_pkg::HUE_FRACTION_BITS_DEF,
    parameter int PFB = rthc_pkg::PERCENT_FRACTION_BITS_DEF,
    parameter int QW  = rthc_pkg::quot_width(HFB, PFB)
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_take,
    input  logic [rthc_pkg::CH_W-1:0]                         i_red,
    input  logic [rthc_pkg::CH_W-1:0]                         i_green,
    input  logic [rthc_pkg::CH_W-1:0]                         i_blue,
    output rthc_pkg::t_ctrl                                   o_ctrl,
    output logic [rthc_pkg::LANES-1:0][rthc_pkg::DIV_W-1:0]   o_div,
    output logic [rthc_pkg::LANES-1:0][rthc_pkg::DIV_W-1:0]   o_rem,
    output logic [rthc_pkg::LANES-1:0][QW-1:0]                o_bits
);

    localparam int NW = QW + rthc_pkg::DIV_W;

    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    // stage 1
    logic                          r_s1_valid;
    logic [rthc_pkg::CH_W-1:0]     r_red, r_green, r_blue, r_mx, r_mn;
    logic [1:0]                    r_sect;
    logic [rthc_pkg::CH_W-1:0]     n_mx, n_mn;
    logic [1:0]                    n_sect;

    always_comb begin
        n_mx = i_red;
        n_mn = i_red;
        if (i_green > n_mx) n_mx = i_green;
        if (i_blue > n_mx)  n_mx = i_blue;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue < n_mn)  n_mn = i_blue;
        // ties go to red, then green
        if (n_mx == i_red) begin
            n_sect = SECT_RED;
        end else if (n_mx == i_green) begin
            n_sect = SECT_GREEN;
        end else begin
            n_sect = SECT_BLUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_take;
        end
        r_red   <= i_red;
        r_green <= i_green;
        r_blue  <= i_blue;
        r_mx    <= n_mx;
        r_mn    <= n_mn;
        r_sect  <= n_sect;
    end

    // stage 2
    logic [rthc_pkg::CH_W-1:0]   d;
    logic [rthc_pkg::CH_W:0]     sum;
    logic [rthc_pkg::CH_W:0]     sat_den;
    logic signed [9:0]           diff;
    logic signed [18:0]          base;
    logic signed [18:0]          h_wide;
    logic [16:0]                 hnum;
    logic [NW-1:0]               hue_num, sat_num, light_num;
    rthc_pkg::t_ctrl             n_ctrl;
    logic [rthc_pkg::LANES-1:0][rthc_pkg::DIV_W-1:0] n_div, n_rem;
    logic [rthc_pkg::LANES-1:0][QW-1:0]              n_bits;

    always_comb begin
        d       = r_mx - r_mn;
        sum     = {1'b0, r_mx} + {1'b0, r_mn};
        sat_den = (sum < 9'd255) ? sum : 9'(10'd510 - {1'b0, sum});

        case (r_sect)
            SECT_RED: begin
                diff = $signed({2'b00, r_green}) - $signed({2'b00, r_blue});
                base = '0;
            end
            SECT_GREEN: begin
                diff = $signed({2'b00, r_blue}) - $signed({2'b00, r_red});
                base = $signed({11'b0, d}) * 19'sd120;
            end
            default: begin
                diff = $signed({2'b00, r_red}) - $signed({2'b00, r_green});
                base = $signed({11'b0, d}) * 19'sd240;
            end
        endcase
        h_wide = 19'(diff) * 19'sd60 + base;
        // only the red sector can go negative
        if (h_wide < 0) h_wide = h_wide + $signed({11'b0, d}) * 19'sd360;
        hnum = 17'(h_wide);

        // numerator 2*num + den over divisor 2*den gives round half up
        hue_num   = (NW'(hnum) << (HFB + 1)) + NW'(d);
        sat_num   = (NW'(16'(d) * 16'd200) << PFB) + NW'(sat_den);
        light_num = (NW'(16'(sum) * 16'd100) << PFB) + NW'(8'd255);

        n_div[rthc_pkg::LANE_HUE]   = {d, 1'b0};
        n_div[rthc_pkg::LANE_SAT]   = {sat_den[rthc_pkg::CH_W-1:0], 1'b0};
        n_div[rthc_pkg::LANE_LIGHT] = 9'd510;

        n_rem[rthc_pkg::LANE_HUE]    = hue_num[NW-1:QW];
        n_rem[rthc_pkg::LANE_SAT]    = sat_num[NW-1:QW];
        n_rem[rthc_pkg::LANE_LIGHT]  = light_num[NW-1:QW];
        n_bits[rthc_pkg::LANE_HUE]   = hue_num[QW-1:0];
        n_bits[rthc_pkg::LANE_SAT]   = sat_num[QW-1:0];
        n_bits[rthc_pkg::LANE_LIGHT] = light_num[QW-1:0];

        n_ctrl.valid = r_s1_valid;
        n_ctrl.gray  = (d == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctrl <= '0;
        end else begin
            o_ctrl <= n_ctrl;
        end
        o_div  <= n_div;
        o_rem  <= n_rem;
        o_bits <= n_bits;
    end

endmodule

@@ rtl/rthc_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rthc_div_cell
// One restoring division step for each lane: shifts in the next numerator
// bit, subtracts the divisor when it fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module rthc_div_cell #(
    parameter int QW = rthc_pkg::quot_width(rthc_pkg::HUE_FRACTION_BITS_DEF,
                                            rthc_pkg::PERCENT_FRACTION_BITS_DEF)
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  rthc_pkg::t_ctrl                                   i_ctrl,
    input  logic [rthc_pkg::LANES-1:0][rthc_pkg::DIV_W-1:0]   i_div,
    input  logic [rthc_pkg::LANES-1:0][rthc_pkg::DIV_W-1:0]   i_rem,
    input  logic [rthc_pkg::LANES-1:0][QW-1:0]                i_bits,
    output rthc_pkg::t_ctrl                                   o_ctrl,
    output logic [rthc_pkg::LANES-1:0][rthc_pkg::DIV_W-1:0]   o_div,
    output logic [rthc_pkg::LANES-1:0][rthc_pkg::DIV_W-1:0]   o_rem,
    output logic [rthc_pkg::LANES-1:0][QW-1:0]                o_bits
);

    logic [rthc_pkg::LANES-1:0][rthc_pkg::DIV_W:0]   trial;
    logic [rthc_pkg::LANES-1:0]                      fits;
    logic [rthc_pkg::LANES-1:0][rthc_pkg::DIV_W-1:0] n_rem;
    logic [rthc_pkg::LANES-1:0][QW-1:0]              n_bits;

    always_comb begin
        for (int l = 0; l < rthc_pkg::LANES; l++) begin
            trial[l] = {i_rem[l], i_bits[l][QW-1]};
            fits[l]  = (trial[l] >= {1'b0, i_div[l]});
            // remainder stays below the divisor, so it fits back in DIV_W bits
            n_rem[l] = fits[l] ? rthc_pkg::DIV_W'(trial[l] - {1'b0, i_div[l]})
                               : rthc_pkg::DIV_W'(trial[l]);
            n_bits[l] = {i_bits[l][QW-2:0], fits[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctrl <= '0;
        end else begin
            o_ctrl <= i_ctrl;
        end
        o_div  <= i_div;
        o_rem  <= n_rem;
        o_bits <= n_bits;
    end

endmodule
